/* sv/pcle_pkg.sv */
package pcle_pkg;

  // request codes carried in s_tuser
  typedef enum logic [2:0] {
    FN_INS_FIRST = 3'd0,
    FN_INS_END   = 3'd1,
    FN_INS_NTH   = 3'd2,
    FN_DEL_FIRST = 3'd3,
    FN_DEL_END   = 3'd4,
    FN_DEL_NTH   = 3'd5,
    FN_DUMP      = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  // operation broadcast along the cell chain
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  localparam int FUNC_BITS   = 3;
  localparam int VALUE_BITS  = 32;
  localparam int POS_BITS    = 7;
  localparam int STATUS_BITS = 2;
  localparam int ITEM_BITS   = 32;
  localparam int COUNT_BITS  = 7;

endpackage

/* sv/pcle_cell.sv */
module pcle_cell import pcle_pkg::*; #(
  parameter int INDEX     = 0,
  parameter int IDX_BITS  = 7,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  cell_op_t             op,
  input  logic [IDX_BITS-1:0]  k,
  input  logic [IDX_BITS-1:0]  last_idx,
  input  logic [WORD_BITS-1:0] new_word,
  input  logic [WORD_BITS-1:0] left,
  input  logic [WORD_BITS-1:0] right,
  input  logic [WORD_BITS-1:0] head,
  output logic [WORD_BITS-1:0] word
);

  localparam logic [IDX_BITS-1:0] IDX = IDX_BITS'(INDEX);

  logic [WORD_BITS-1:0] word_next;

  always_comb begin
    word_next = word;
    case (op)
      OP_INSERT: begin
        if (IDX == k) begin
          word_next = new_word;
        end else if (IDX > k) begin
          word_next = left;
        end
      end
      OP_DELETE: begin
        if (IDX >= k) begin
          word_next = right;
        end
      end
      OP_ROTATE: begin
        // last occupied cell wraps around to the head
        if (IDX == last_idx) begin
          word_next = head;
        end else begin
          word_next = right;
        end
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

/* sv/positional_circular_list_engine.sv */
// ordered list engine: keeps up to CAPACITY signed words in list order
// input channel s_*: one request per transfer, s_tuser carries the request code
//   (insert first/end/nth, delete first/end/nth, dump), s_tdata the value and
//   the one-based position
// output channel m_*: results with status, item, entry count; tlast marks the
//   final result of a request
// the list lives in a chain of cells, cell i holding entry i+1; insert and
//   delete shift all the cells behind the position by one at once
// a non-dump request gives its one result in the cycle after accept, and a
//   new request is taken every cycle while the output is drained
// dump: results follow one per cycle while the receiver keeps up, the first
//   loaded from the dump state that the accept enters; the chain rotates by
//   one cell per result and is back in order after the last one
// reset clears the entry count and the control state; cell words are not
//   cleared, no clearing pass is needed
// when the receiver stalls, the result is held in the output register and no
//   new request is taken, a dump pauses in place
module positional_circular_list_engine import pcle_pkg::*; #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], position[38:32], zero[39]
  input  logic [7:0]  s_tuser,   // func[2:0], zero[7:3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // status[1:0], item[33:2], count[40:34], zero[47:41]
  output logic        m_tlast
);

  localparam int CW  = $clog2(CAPACITY + 1);           // count width
  localparam int WW  = ((CW > POS_BITS) ? CW : POS_BITS) + 1;  // compare width
  localparam int EXT = (WORD_BITS > ITEM_BITS) ? WORD_BITS : ITEM_BITS;

  // control registers
  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   rem, rem_next;

  // output register
  logic                   out_status_load;
  status_t                out_status, ld_status;
  logic [ITEM_BITS-1:0]   out_item, ld_item;
  logic [COUNT_BITS-1:0]  out_count;
  logic                   out_last, ld_last;

  // chain
  logic [WORD_BITS-1:0]   words [CAPACITY];
  cell_op_t               op;
  logic [CW-1:0]          k;
  logic [CW-1:0]          last_idx;
  logic [WORD_BITS-1:0]   new_word;

  // request decode
  func_t                  func;
  logic [POS_BITS-1:0]    position;
  logic [WW-1:0]          pos_w, count_w, ins_p, del_p;
  logic                   out_free;
  logic signed [EXT-1:0]  head_ext;

  assign func     = func_t'(s_tuser[FUNC_BITS-1:0]);
  assign position = s_tdata[VALUE_BITS +: POS_BITS];
  assign new_word = WORD_BITS'(s_tdata[VALUE_BITS-1:0]);
  assign pos_w    = WW'(position);
  assign count_w  = WW'(count);
  assign last_idx = count - CW'(1);
  assign head_ext = EXT'($signed(words[0]));

  // one-based target position of the request
  always_comb begin
    case (func)
      FN_INS_FIRST: ins_p = WW'(1);
      FN_INS_END:   ins_p = count_w + WW'(1);
      default:      ins_p = pos_w;
    endcase
    case (func)
      FN_DEL_FIRST: del_p = WW'(1);
      FN_DEL_END:   del_p = count_w;
      default:      del_p = pos_w;
    endcase
  end

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;

  always_comb begin
    state_next      = state;
    count_next      = count;
    rem_next        = rem;
    op              = OP_HOLD;
    k               = '0;
    out_status_load = 1'b0;
    ld_status       = STAT_OK;
    ld_item         = '0;
    ld_last         = 1'b1;
    case (state)
      S_IDLE: begin
        if (s_tvalid && out_free) begin
          out_status_load = 1'b1;
          case (func)
            FN_INS_FIRST, FN_INS_END, FN_INS_NTH: begin
              // position is checked before the pool
              if (ins_p == '0 || ins_p > count_w + WW'(1)) begin
                ld_status = STAT_BAD_POS;
              end else if (count_w >= WW'(CAPACITY)) begin
                ld_status = STAT_FULL;
              end else begin
                op         = OP_INSERT;
                k          = CW'(ins_p - WW'(1));
                count_next = count + CW'(1);
              end
            end
            FN_DEL_FIRST, FN_DEL_END, FN_DEL_NTH: begin
              if (func == FN_DEL_NTH && position == '0) begin
                ld_status = STAT_BAD_POS;
              end else if (count == '0) begin
                ld_status = STAT_EMPTY;
              end else if (del_p > count_w) begin
                ld_status = STAT_BAD_POS;
              end else begin
                op         = OP_DELETE;
                k          = CW'(del_p - WW'(1));
                count_next = count - CW'(1);
              end
            end
            FN_DUMP: begin
              if (count == '0) begin
                ld_status = STAT_EMPTY;
              end else begin
                out_status_load = 1'b0;
                rem_next        = count;
                state_next      = S_DUMP;
              end
            end
            default: ld_status = STAT_BAD_POS;
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          // emit the head and rotate the chain by one
          out_status_load = 1'b1;
          ld_item         = head_ext[ITEM_BITS-1:0];
          ld_last         = (rem == CW'(1));
          op              = OP_ROTATE;
          rem_next        = rem - CW'(1);
          if (rem == CW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rem      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rem   <= rem_next;
      if (out_status_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_status_load) begin
      out_status <= ld_status;
      out_item   <= ld_item;
      out_count  <= COUNT_BITS'(count_next);
      out_last   <= ld_last;
    end
  end

  assign m_tdata = {7'd0, out_count, out_item, out_status};
  assign m_tlast = out_last;

  // cell chain, each cell talks to its left and right neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = words[i];
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    pcle_cell #(
      .INDEX     (i),
      .IDX_BITS  (CW),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk      (clk),
      .op       (op),
      .k        (k),
      .last_idx (last_idx),
      .new_word (new_word),
      .left     (left_w),
      .right    (right_w),
      .head     (words[0]),
      .word     (words[i])
    );
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> count != '0 && rem != '0)
    else $error("dump running on empty list");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !(s_tvalid && s_tready) |=> $stable(count))
    else $error("count changed without a request");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && func != FN_DUMP) |=> m_tvalid && m_tlast)
    else $error("missing result for request");

  a_dump_stalls_input: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> !s_tready)
    else $error("request taken during dump");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import pcle_pkg::*;

  // request code with no operation behind it
  localparam logic [2:0] FN_UNUSED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    status_t     status;
    logic [31:0] item;
    logic [6:0]  count;
    logic        last;
  } list_result_t;

  // ordered list predictor plus the results it still owes
  class list_tracker;
    localparam int POOL_SLOTS = 64;

    logic [31:0]  list_words[$];
    list_result_t awaited[$];
    int mismatches;
    int compared;
    int inserts;
    int deletes;
    int dumps;
    int refused;
    int full_hits;
    int max_len;

    task report_mismatch(input string msg);
      if (mismatches < 60)
        $display("[%0t] error: %s", $time, msg);
      mismatches++;
    endtask

    function void push_result(input status_t st, input logic [31:0] word, input logic last);
      list_result_t r;
      r.status = st;
      r.item   = word;
      r.count  = 7'(list_words.size());
      r.last   = last;
      awaited.push_back(r);
    endfunction

    // accepted request: update the list and queue what it must produce
    function void note_request(input logic [2:0] fn, input logic [31:0] val,
                               input logic [6:0] pos);
      int n;
      int p;
      status_t st;
      n  = list_words.size();
      st = STAT_OK;
      case (fn)
        FN_INS_FIRST, FN_INS_END, FN_INS_NTH: begin
          p = (fn == FN_INS_FIRST) ? 1 : (fn == FN_INS_END) ? n + 1 : int'(pos);
          // position is judged before the pool
          if (p == 0 || p > n + 1) st = STAT_BAD_POS;
          else if (n >= POOL_SLOTS) st = STAT_FULL;
          else begin
            list_words.insert(p - 1, val);
            inserts++;
          end
        end
        FN_DEL_FIRST, FN_DEL_END, FN_DEL_NTH: begin
          p = (fn == FN_DEL_FIRST) ? 1 : (fn == FN_DEL_END) ? n : int'(pos);
          if (fn == FN_DEL_NTH && pos == 0) st = STAT_BAD_POS;
          else if (n == 0) st = STAT_EMPTY;
          else if (p > n) st = STAT_BAD_POS;
          else begin
            list_words.delete(p - 1);
            deletes++;
          end
        end
        FN_DUMP: begin
          if (n == 0) st = STAT_EMPTY;
          else dumps++;
        end
        default: st = STAT_BAD_POS;
      endcase
      if (st != STAT_OK) refused++;
      if (st == STAT_FULL) full_hits++;
      if (list_words.size() > max_len) max_len = list_words.size();
      if (fn == FN_DUMP && st == STAT_OK) begin
        for (int i = 0; i < n; i++)
          push_result(STAT_OK, list_words[i], i == n - 1);
      end else begin
        push_result(st, '0, 1'b1);
      end
    endfunction

    task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                  compared, name, got, want));
    endtask

    task check_result(input logic [1:0] st, input logic [31:0] word,
                      input logic [6:0] cnt, input logic last);
      list_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status %0d item %0h count %0d",
                                  st, word, cnt));
      end else begin
        want = awaited.pop_front();
        compare_field("status", 32'(st), 32'(want.status));
        compare_field("item", word, want.item);
        compare_field("count", 32'(cnt), 32'(want.count));
        compare_field("last", 32'(last), 32'(want.last));
        compared++;
      end
    endtask

    task flush_leftovers();
      while (awaited.size() != 0) begin
        report_mismatch($sformatf("result never came: item %0h count %0d",
                                  awaited[0].item, awaited[0].count));
        void'(awaited.pop_front());
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // value[31:0], position[38:32], zero[39]
  logic [7:0]  s_tuser;   // func[2:0], zero[7:3]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // status[1:0], item[33:2], count[40:34], zero[47:41]
  logic        m_tlast;

  bit          no_idle;
  int unsigned cycle_count = 0;
  list_tracker tracker = new();

  always #2 clk = ~clk;

  positional_circular_list_engine #(
    .CAPACITY  (64),
    .WORD_BITS (32)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      tracker.check_result(m_tdata[1:0], m_tdata[33:2], m_tdata[40:34], m_tlast);
  end

  // receiver: random stall before each result
  initial begin
    int gap;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [2:0] fn, input logic [31:0] val,
                              input logic [6:0] pos);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {5'b0, fn};
    s_tdata  <= {1'b0, pos, val};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(fn, val, pos);
  endtask

  // lean: 0 balanced, 1 mostly inserts, 2 mostly deletes
  task automatic random_request(input int lean);
    int n;
    int r;
    int ins_share;
    logic [2:0] fn;
    logic [6:0] pos;
    n = tracker.list_words.size();
    ins_share = (lean == 1) ? 70 : (lean == 2) ? 20 : 45;
    r = $urandom_range(0, 99);
    if (r < ins_share) begin
      case ($urandom_range(0, 2))
        0: fn = FN_INS_FIRST;
        1: fn = FN_INS_END;
        default: fn = FN_INS_NTH;
      endcase
      pos = 7'($urandom_range(1, n + 1));
    end else if (r < 90) begin
      case ($urandom_range(0, 2))
        0: fn = FN_DEL_FIRST;
        1: fn = FN_DEL_END;
        default: fn = FN_DEL_NTH;
      endcase
      pos = (n == 0) ? 7'd1 : 7'($urandom_range(1, n));
    end else if (r < 98) begin
      fn  = FN_DUMP;
      pos = 7'($urandom);
    end else begin
      fn  = FN_UNUSED;
      pos = 7'($urandom);
    end
    // some positions anywhere in the field, mostly out of range
    if ($urandom_range(0, 9) == 0) pos = 7'($urandom_range(0, 127));
    send_request(fn, random_word(), pos);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    logic [2:0] fn;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    no_idle  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, bad positions, extremes, head and tail edits
    send_request(FN_DUMP, $urandom, 7'($urandom));
    send_request(FN_DEL_FIRST, $urandom, 7'($urandom));
    send_request(FN_DEL_END, $urandom, 7'($urandom));
    send_request(FN_DEL_NTH, $urandom, 7'd0);
    send_request(FN_DEL_NTH, $urandom, 7'd1);
    send_request(FN_INS_NTH, 32'h1234_5678, 7'd0);
    send_request(FN_INS_NTH, 32'h1234_5678, 7'd2);
    send_request(FN_INS_NTH, 32'h1234_5678, 7'd127);
    send_request(FN_INS_FIRST, 32'h7FFF_FFFF, 7'($urandom));
    send_request(FN_INS_END, 32'h8000_0000, 7'($urandom));
    send_request(FN_INS_NTH, 32'h0000_0000, 7'd2);
    send_request(FN_INS_NTH, 32'hFFFF_FFFF, 7'd4);
    send_request(FN_INS_NTH, 32'h5555_5555, 7'd1);
    send_request(FN_INS_NTH, 32'hAAAA_AAAA, 7'd3);
    send_request(FN_DUMP, $urandom, 7'($urandom));
    send_request(FN_DEL_NTH, $urandom, 7'd7);
    send_request(FN_DEL_NTH, $urandom, 7'd127);
    send_request(FN_DEL_NTH, $urandom, 7'd3);
    send_request(FN_DEL_FIRST, $urandom, 7'($urandom));
    send_request(FN_DEL_END, $urandom, 7'($urandom));
    send_request(FN_UNUSED, $urandom, 7'($urandom));
    send_request(FN_DUMP, $urandom, 7'($urandom));
    send_request(FN_DEL_NTH, $urandom, 7'd3);
    send_request(FN_DUMP, $urandom, 7'($urandom));

    // hold off until the block has answered everything
    wait_drained();

    // mostly inserts, then a balanced mix, idling style changes every 20 requests
    for (int i = 0; i < 80; i++) begin
      if (i % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
      random_request(i < 40 ? 1 : 0);
    end

    // fill the pool to the brim with random insert kinds
    no_idle = 1'b0;
    while (tracker.list_words.size() < 64) begin
      n = tracker.list_words.size();
      case ($urandom_range(0, 2))
        0: fn = FN_INS_FIRST;
        1: fn = FN_INS_END;
        default: fn = FN_INS_NTH;
      endcase
      send_request(fn, random_word(), 7'($urandom_range(1, n + 1)));
    end

    // full pool: full refusals, and a bad position still wins over the full flag
    send_request(FN_INS_FIRST, random_word(), 7'($urandom));
    send_request(FN_INS_END, random_word(), 7'($urandom));
    send_request(FN_INS_NTH, random_word(), 7'd65);
    send_request(FN_INS_NTH, random_word(), 7'd66);
    send_request(FN_INS_NTH, random_word(), 7'd0);
    send_request(FN_DUMP, $urandom, 7'($urandom));
    send_request(FN_DEL_NTH, $urandom, 7'd64);
    send_request(FN_INS_NTH, random_word(), 7'd64);
    send_request(FN_DEL_NTH, $urandom, 7'd65);

    // churn near the top, then empty the list with random delete kinds
    no_idle = 1'b1;
    for (int i = 0; i < 20; i++)
      random_request(1);
    no_idle = 1'b0;
    while (tracker.list_words.size() > 0) begin
      n = tracker.list_words.size();
      case ($urandom_range(0, 2))
        0: fn = FN_DEL_FIRST;
        1: fn = FN_DEL_END;
        default: fn = FN_DEL_NTH;
      endcase
      send_request(fn, $urandom, 7'($urandom_range(1, n)));
      if ($urandom_range(0, 15) == 0) send_request(FN_DUMP, $urandom, 7'($urandom));
    end
    send_request(FN_DUMP, $urandom, 7'($urandom));

    for (int i = 0; i < 30; i++) begin
      if (i % 15 == 0) no_idle = ($urandom_range(0, 2) == 0);
      random_request(i < 20 ? 1 : 0);
    end

    // closing: everything answered, then room for a full dump to misbehave
    wait_drained();
    repeat (80) @(posedge clk);
    tracker.flush_leftovers();

    $display("covered %0d inserts, %0d deletes, %0d dumps and %0d refused requests",
             tracker.inserts, tracker.deletes, tracker.dumps, tracker.refused);
    $display("%0d results compared, longest list %0d, %0d full-pool refusals",
             tracker.compared, tracker.max_len, tracker.full_hits);
    if (tracker.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
